// ----- hdl/three_wire_serial_shift_engine_assert.svh -----
// ----------------------------------------------------------------------------
// three wire serial shift engine assertion macros
// shorthand for clocked implication checks, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_SERIAL_SHIFT_ENGINE_ASSERT_SVH
`define THREE_WIRE_SERIAL_SHIFT_ENGINE_ASSERT_SVH

// same-cycle implication
`define TWS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tws same-cycle check failed");

// next-cycle implication
`define TWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tws next-cycle check failed");

`endif

// ----- hdl/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg
// shared widths, phase codes and the per-tick result word type
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int WORD_W   = 15;
    localparam int COUNT_W  = 4;
    localparam int MAX_BITS = 15;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TXHI   = 3'd1,
        PH_TXLO   = 3'd2,
        PH_TURN   = 3'd3,
        PH_RXLO   = 3'd4,
        PH_RXHI   = 3'd5,
        PH_FINISH = 3'd6
    } t_phase;

    typedef struct packed {
        logic              clk_level;
        logic              data_out;
        logic              drive_enable;
        logic              busy_res;
        logic              done_res;
        logic [WORD_W-1:0] rx_word;
    } t_result;

    // saturate a requested bit count
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] lim;
        lim = COUNT_W'(MAX_BITS);
        return (c > lim) ? lim : c;
    endfunction

endpackage

// ----- hdl/three_wire_serial_shift_engine.sv -----
// ----------------------------------------------------------------------------
// three_wire_serial_shift_engine
// half-duplex three-wire serial transfer engine, one word per half-bit tick
// ----------------------------------------------------------------------------
// usage:
//   every input word is one half-bit tick; it carries the start request,
//   the transmit word, the send and receive bit counts and the sampled
//   data line. every input word yields exactly one output word with the
//   clock and data line levels, the drive enable, busy, done and the
//   received word (nonzero only with done).
//   input channel: i_in_valid / o_in_stall. output channel: o_out_valid /
//   i_out_stall. a word moves when valid is high and stall is low.
//   output valid follows in the cycle after input acceptance; one word is
//   taken per cycle while the output is not stalled, the sequencer state and
//   the output register advancing together in the same edge.
//   a transfer of n sent and m received bits spans 2n + 2m + 3 ticks.
//   when the receiver stalls, the output register holds its word and the
//   input side stalls the same cycle; no tick is lost or repeated.
//   reset (synchronous, active low) returns the sequencer to idle with the
//   clock low and the data line driven, and empties the output register.
// ----------------------------------------------------------------------------
`include "three_wire_serial_shift_engine_assert.svh"

module three_wire_serial_shift_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_start_req,
    input  logic [tws_pkg::WORD_W-1:0]  i_tx_word,
    input  logic [tws_pkg::COUNT_W-1:0] i_out_count,
    input  logic [tws_pkg::COUNT_W-1:0] i_in_count,
    input  logic                        i_data_line,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_clk_level,
    output logic                        o_data_out,
    output logic                        o_drive_enable,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic [tws_pkg::WORD_W-1:0]  o_rx_word
);

    logic             in_accept;
    logic             r_out_valid;
    tws_pkg::t_result r_out;
    tws_pkg::t_result core_result;
    tws_pkg::t_phase  core_phase;

    // input is held off only while a finished word waits on a stalled receiver
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    tws_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_start_req (i_start_req),
        .i_tx_word   (i_tx_word),
        .i_out_count (i_out_count),
        .i_in_count  (i_in_count),
        .i_data_line (i_data_line),
        .o_result    (core_result),
        .o_phase     (core_phase)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_clk_level    = r_out.clk_level;
    assign o_data_out     = r_out.data_out;
    assign o_drive_enable = r_out.drive_enable;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_rx_word      = r_out.rx_word;

    // received word only shows with done
    `TWS_ASSERT_SAME(a_rx_only_with_done, o_out_valid && !o_done_res, o_rx_word == '0)
    // data line is always released by the completion tick
    `TWS_ASSERT_SAME(a_done_released, o_out_valid && o_done_res, !o_drive_enable && !o_busy_res)
    // a completion tick returns the sequencer to idle
    `TWS_ASSERT_NEXT(a_finish_to_idle, in_accept && core_phase == tws_pkg::PH_FINISH,
        core_phase == tws_pkg::PH_IDLE && o_done_res)

endmodule

// ----- hdl/tws_core.sv -----
// ----------------------------------------------------------------------------
// tws_core
// serial sequencer: phase state, shift registers and bit counters, advanced
// by one half-bit tick on every accepted word
// ----------------------------------------------------------------------------
module tws_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_start_req,
    input  logic [tws_pkg::WORD_W-1:0]  i_tx_word,
    input  logic [tws_pkg::COUNT_W-1:0] i_out_count,
    input  logic [tws_pkg::COUNT_W-1:0] i_in_count,
    input  logic                        i_data_line,
    output tws_pkg::t_result            o_result,
    output tws_pkg::t_phase             o_phase
);

    tws_pkg::t_phase             r_phase, n_phase;
    logic [tws_pkg::WORD_W-1:0]  r_tx_shift, n_tx_shift;
    logic [tws_pkg::WORD_W-1:0]  r_rx_shift, n_rx_shift;
    logic [tws_pkg::COUNT_W-1:0] r_send_left, n_send_left;
    logic [tws_pkg::COUNT_W-1:0] r_receive_left, n_receive_left;
    logic                        r_clock, n_clock;
    logic                        r_drive, n_drive;
    logic                        dout;
    logic                        busy;
    logic                        done;
    logic [tws_pkg::WORD_W-1:0]  rxo;
    logic [tws_pkg::WORD_W-1:0]  rx_sampled;

    // state registers, advanced only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tws_pkg::PH_IDLE;
            r_tx_shift     <= '0;
            r_rx_shift     <= '0;
            r_send_left    <= '0;
            r_receive_left <= '0;
            r_clock        <= 1'b0;
            r_drive        <= 1'b1;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_tx_shift     <= n_tx_shift;
            r_rx_shift     <= n_rx_shift;
            r_send_left    <= n_send_left;
            r_receive_left <= n_receive_left;
            r_clock        <= n_clock;
            r_drive        <= n_drive;
        end
    end

    // sampled line replaces the lsb of the receive word
    assign rx_sampled = {r_rx_shift[tws_pkg::WORD_W-1:1], i_data_line};

    // next phase and per-tick outputs
    always_comb begin
        n_phase        = r_phase;
        n_tx_shift     = r_tx_shift;
        n_rx_shift     = r_rx_shift;
        n_send_left    = r_send_left;
        n_receive_left = r_receive_left;
        n_clock        = r_clock;
        n_drive        = r_drive;
        dout           = 1'b0;
        busy           = 1'b1;
        done           = 1'b0;
        rxo            = '0;
        case (r_phase)
            tws_pkg::PH_IDLE: begin
                if (i_start_req) begin
                    n_tx_shift     = i_tx_word;
                    n_rx_shift     = '0;
                    n_send_left    = tws_pkg::clamp_count(i_out_count);
                    n_receive_left = tws_pkg::clamp_count(i_in_count);
                    n_drive        = 1'b1;
                    n_clock        = 1'b0;
                    n_phase        = (n_send_left != '0) ? tws_pkg::PH_TXHI
                                                         : tws_pkg::PH_TURN;
                end else begin
                    busy = 1'b0;
                end
            end
            tws_pkg::PH_TXHI: begin
                n_clock = 1'b1;
                dout    = r_tx_shift[0];
                n_phase = tws_pkg::PH_TXLO;
            end
            tws_pkg::PH_TXLO: begin
                n_clock     = 1'b0;
                dout        = r_tx_shift[0];
                n_tx_shift  = r_tx_shift >> 1;
                n_send_left = (r_send_left != '0) ? r_send_left - 1'b1 : r_send_left;
                n_phase     = (n_send_left != '0) ? tws_pkg::PH_TXHI : tws_pkg::PH_TURN;
            end
            tws_pkg::PH_TURN: begin
                n_drive = 1'b0;
                n_clock = 1'b1;
                n_phase = (r_receive_left != '0) ? tws_pkg::PH_RXLO : tws_pkg::PH_FINISH;
            end
            tws_pkg::PH_RXLO: begin
                n_clock        = 1'b0;
                n_receive_left = (r_receive_left != '0) ? r_receive_left - 1'b1
                                                        : r_receive_left;
                n_rx_shift     = (n_receive_left != '0) ? (rx_sampled << 1) : rx_sampled;
                n_phase        = tws_pkg::PH_RXHI;
            end
            tws_pkg::PH_RXHI: begin
                n_clock = 1'b1;
                n_phase = (r_receive_left != '0) ? tws_pkg::PH_RXLO : tws_pkg::PH_FINISH;
            end
            tws_pkg::PH_FINISH: begin
                n_clock = 1'b0;
                busy    = 1'b0;
                done    = 1'b1;
                rxo     = r_rx_shift;
                n_phase = tws_pkg::PH_IDLE;
            end
            default: begin
                n_clock = 1'b0;
                busy    = 1'b0;
                n_phase = tws_pkg::PH_IDLE;
            end
        endcase
    end

    // result word for this tick
    always_comb begin
        o_result.clk_level    = n_clock;
        o_result.data_out     = dout;
        o_result.drive_enable = n_drive;
        o_result.busy_res     = busy;
        o_result.done_res     = done;
        o_result.rx_word      = rxo;
    end

    assign o_phase = r_phase;

endmodule

// ----- test/three_wire_serial_shift_engine_tb.sv -----
// ----------------------------------------------------------------------------
// three_wire_serial_shift_engine_tb
// drives half-bit ticks into the serial shift engine and checks every output
// word against a tick-by-tick prediction of the line levels, busy, done and
// the received word; covers zero and full bit counts, start requests while
// busy and back-to-back transfers, with random bursts, gaps and stalls
// ----------------------------------------------------------------------------
module three_wire_serial_shift_engine_tb;

    localparam int ITEM_TARGET  = 750;
    localparam int MIN_TRANSFER = 40;
    localparam int LIMIT_CYCLES = 150000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic                        start;
        logic [tws_pkg::WORD_W-1:0]  tx;
        logic [tws_pkg::COUNT_W-1:0] n_out;
        logic [tws_pkg::COUNT_W-1:0] n_in;
        logic                        line;
    } t_tick;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_stall;
    logic                        i_start_req   = 1'b0;
    logic [tws_pkg::WORD_W-1:0]  i_tx_word     = '0;
    logic [tws_pkg::COUNT_W-1:0] i_out_count   = '0;
    logic [tws_pkg::COUNT_W-1:0] i_in_count    = '0;
    logic                        i_data_line   = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall   = 1'b0;
    logic                        o_clk_level;
    logic                        o_data_out;
    logic                        o_drive_enable;
    logic                        o_busy_res;
    logic                        o_done_res;
    logic [tws_pkg::WORD_W-1:0]  o_rx_word;

    t_tick            pending_ticks[$];
    tws_pkg::t_result expected_levels[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 1;
    int          gap_left       = 0;
    int          mode_left      = 0;
    t_stall_mode stall_mode     = STALL_NONE;

    // predicted engine state
    tws_pkg::t_phase             eng_phase = tws_pkg::PH_IDLE;
    logic [tws_pkg::WORD_W-1:0]  eng_tx    = '0;
    logic [tws_pkg::WORD_W-1:0]  eng_rx    = '0;
    logic [tws_pkg::COUNT_W-1:0] eng_send  = '0;
    logic [tws_pkg::COUNT_W-1:0] eng_recv  = '0;
    logic                        eng_clk   = 1'b0;
    logic                        eng_drive = 1'b1;

    three_wire_serial_shift_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_req    (i_start_req),
        .i_tx_word      (i_tx_word),
        .i_out_count    (i_out_count),
        .i_in_count     (i_in_count),
        .i_data_line    (i_data_line),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_clk_level    (o_clk_level),
        .o_data_out     (o_data_out),
        .o_drive_enable (o_drive_enable),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_word      (o_rx_word)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // counts above the register width limit saturate
    function automatic logic [tws_pkg::COUNT_W-1:0] sat_bits(
        input logic [tws_pkg::COUNT_W-1:0] c);
        return (c > tws_pkg::COUNT_W'(tws_pkg::MAX_BITS)) ?
               tws_pkg::COUNT_W'(tws_pkg::MAX_BITS) : c;
    endfunction

    // advance the predicted engine by one half-bit tick
    function automatic tws_pkg::t_result predict_line_levels(input t_tick t);
        tws_pkg::t_result r;
        r          = '0;
        r.busy_res = 1'b1;
        case (eng_phase)
            tws_pkg::PH_IDLE: begin
                if (t.start) begin
                    eng_tx    = t.tx;
                    eng_rx    = '0;
                    eng_send  = sat_bits(t.n_out);
                    eng_recv  = sat_bits(t.n_in);
                    eng_drive = 1'b1;
                    eng_clk   = 1'b0;
                    eng_phase = (eng_send != '0) ? tws_pkg::PH_TXHI : tws_pkg::PH_TURN;
                end else begin
                    r.busy_res = 1'b0;
                end
            end
            tws_pkg::PH_TXHI: begin
                eng_clk    = 1'b1;
                r.data_out = eng_tx[0];
                eng_phase  = tws_pkg::PH_TXLO;
            end
            tws_pkg::PH_TXLO: begin
                eng_clk    = 1'b0;
                r.data_out = eng_tx[0];
                eng_tx     = eng_tx >> 1;
                if (eng_send != '0) eng_send = eng_send - 1'b1;
                eng_phase  = (eng_send != '0) ? tws_pkg::PH_TXHI : tws_pkg::PH_TURN;
            end
            tws_pkg::PH_TURN: begin
                eng_drive = 1'b0;
                eng_clk   = 1'b1;
                eng_phase = (eng_recv != '0) ? tws_pkg::PH_RXLO : tws_pkg::PH_FINISH;
            end
            tws_pkg::PH_RXLO: begin
                eng_clk = 1'b0;
                eng_rx  = {eng_rx[tws_pkg::WORD_W-1:1], t.line};
                if (eng_recv != '0) eng_recv = eng_recv - 1'b1;
                if (eng_recv != '0) eng_rx = eng_rx << 1;
                eng_phase = tws_pkg::PH_RXHI;
            end
            tws_pkg::PH_RXHI: begin
                eng_clk   = 1'b1;
                eng_phase = (eng_recv != '0) ? tws_pkg::PH_RXLO : tws_pkg::PH_FINISH;
            end
            tws_pkg::PH_FINISH: begin
                eng_clk    = 1'b0;
                r.busy_res = 1'b0;
                r.done_res = 1'b1;
                r.rx_word  = eng_rx;
                eng_phase  = tws_pkg::PH_IDLE;
            end
            default: begin
                eng_clk    = 1'b0;
                r.busy_res = 1'b0;
                eng_phase  = tws_pkg::PH_IDLE;
            end
        endcase
        r.clk_level    = eng_clk;
        r.drive_enable = eng_drive;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_tick(input logic start, input logic [tws_pkg::WORD_W-1:0] tx,
                             input logic [tws_pkg::COUNT_W-1:0] n_out,
                             input logic [tws_pkg::COUNT_W-1:0] n_in,
                             input logic line);
        t_tick t;
        t.start = start;
        t.tx    = tx;
        t.n_out = n_out;
        t.n_in  = n_in;
        t.line  = line;
        pending_ticks.push_back(t);
    endtask

    // one start tick followed by every busy tick of the transfer, completion included;
    // busy ticks carry random fields and a start request that must be ignored
    task automatic push_transfer(input logic [tws_pkg::WORD_W-1:0] tx,
                                 input logic [tws_pkg::COUNT_W-1:0] n_out,
                                 input logic [tws_pkg::COUNT_W-1:0] n_in,
                                 input logic hold_start);
        int busy_ticks;
        busy_ticks = 2 * int'(sat_bits(n_out)) + 2 * int'(sat_bits(n_in)) + 2;
        push_tick(1'b1, tx, n_out, n_in, 1'($urandom_range(0, 1)));
        repeat (busy_ticks)
            push_tick(hold_start | 1'($urandom_range(0, 1)),
                      tws_pkg::WORD_W'($urandom_range(0, 32767)),
                      tws_pkg::COUNT_W'($urandom_range(0, 15)),
                      tws_pkg::COUNT_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
    endtask

    // stimulus and end of run
    initial begin
        int n_out;
        int n_in;
        int transfers;
        // directed: field extremes, zero counts, start held through completion,
        // back-to-back transfers
        push_tick(1'b0, 15'h7fff, 4'hf, 4'hf, 1'b1);
        push_transfer(15'h7fff, 4'd0, 4'd0, 1'b1);
        push_transfer(15'h0001, 4'd1, 4'd1, 1'b0);
        push_tick(1'b0, 15'h0000, 4'h0, 4'h0, 1'b0);
        push_transfer(15'h5555, 4'd2, 4'd0, 1'b1);
        push_transfer(15'h2aaa, 4'd0, 4'd2, 1'b0);

        // random: mostly well-formed transfers, some idle ticks and noise
        transfers = 0;
        while (pending_ticks.size() < ITEM_TARGET || transfers < MIN_TRANSFER) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(3, 12))
                        push_tick(1'($urandom_range(0, 1)),
                                  tws_pkg::WORD_W'($urandom_range(0, 32767)),
                                  tws_pkg::COUNT_W'($urandom_range(0, 15)),
                                  tws_pkg::COUNT_W'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)));
                end
                1, 2: begin
                    repeat ($urandom_range(1, 4))
                        push_tick(1'b0, tws_pkg::WORD_W'($urandom_range(0, 32767)),
                                  tws_pkg::COUNT_W'($urandom_range(0, 15)),
                                  tws_pkg::COUNT_W'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)));
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        n_out = $urandom_range(8, 15);
                        n_in  = $urandom_range(8, 15);
                    end else begin
                        n_out = $urandom_range(0, 4);
                        n_in  = $urandom_range(0, 4);
                    end
                    push_transfer(tws_pkg::WORD_W'($urandom_range(0, 32767)),
                                  tws_pkg::COUNT_W'(n_out), tws_pkg::COUNT_W'(n_in),
                                  1'($urandom_range(0, 4) == 0));
                    transfers++;
                end
            endcase
        end

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (pending_ticks.size() != 0 || i_in_valid || expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_levels.size() != 0)
            report_mismatch("words never received", expected_levels.size(), 0);

        if (mismatch_count == 0) begin
            $display("three_wire_serial_shift_engine_tb: clean");
        end else begin
            $display("three_wire_serial_shift_engine_tb: errors");
        end
        $finish;
    end

    // driver: bursts of ticks with random gaps, payload held while stalled
    always @(posedge i_clk) begin : drive_ticks
        t_tick acc;
        t_tick nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                acc.start = i_start_req;
                acc.tx    = i_tx_word;
                acc.n_out = i_out_count;
                acc.n_in  = i_in_count;
                acc.line  = i_data_line;
                expected_levels.push_back(predict_line_levels(acc));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    nxt = pending_ticks.pop_front();
                    i_in_valid  <= 1'b1;
                    i_start_req <= nxt.start;
                    i_tx_word   <= nxt.tx;
                    i_out_count <= nxt.n_out;
                    i_in_count  <= nxt.n_in;
                    i_data_line <= nxt.line;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, in one of four randomly chosen modes, each held for a random run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 9) < 6);
                STALL_PERIODIC: i_out_stall <= (cycle_count % 3 == 0);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    // monitor: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        tws_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("word with nothing expected", int'(o_rx_word), 0);
            end else begin
                want = expected_levels.pop_front();
                if (o_clk_level !== want.clk_level)
                    report_mismatch("clk_level", int'(o_clk_level), int'(want.clk_level));
                if (o_data_out !== want.data_out)
                    report_mismatch("data_out", int'(o_data_out), int'(want.data_out));
                if (o_drive_enable !== want.drive_enable)
                    report_mismatch("drive_enable", int'(o_drive_enable),
                                    int'(want.drive_enable));
                if (o_busy_res !== want.busy_res)
                    report_mismatch("busy_res", int'(o_busy_res), int'(want.busy_res));
                if (o_done_res !== want.done_res)
                    report_mismatch("done_res", int'(o_done_res), int'(want.done_res));
                if (o_rx_word !== want.rx_word)
                    report_mismatch("rx_word", int'(o_rx_word), int'(want.rx_word));
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("three_wire_serial_shift_engine_tb: errors");
            $finish;
        end
    end

endmodule

// ----- three_wire_serial_shift_engine.f -----
+incdir+hdl
hdl/tws_pkg.sv
hdl/tws_core.sv
hdl/three_wire_serial_shift_engine.sv
test/three_wire_serial_shift_engine_tb.sv
